[sv/cbts_pkg.sv]
package cbts_pkg;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_SEG1 = 2'd1,
        PH_SEG2 = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REG_PHASE1 = 2'd0,
        REG_PHASE2 = 2'd1,
        REG_JUMP   = 2'd2
    } t_reg_idx;

    localparam int unsigned PHASE1_W = 5;
    localparam int unsigned PHASE2_W = 4;
    localparam int unsigned JUMP_W   = 3;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned IDX_W    = 2;

    localparam logic [PHASE1_W-1:0] PHASE1_RST = 5'd8;
    localparam logic [PHASE2_W-1:0] PHASE2_RST = 4'd7;
    localparam logic [JUMP_W-1:0]   JUMP_RST   = 3'd1;

endpackage

[sv/can_bit_timing_sync_top.sv]
// CAN bit timing with hard and soft resynchronization, one transaction per
// time quantum. The input channel carries edge_event, hs_write and hs_value;
// the output channel returns sample_strobe, write_strobe and phase_now.
// Both channels use valid and stall; a transaction completes when valid is
// high and stall is low.
// An accepted transaction is held in an input register, processed against
// the timing state and written into the result register, from which the
// result is offered. One transaction can be accepted in every cycle while
// the receiver does not stall. When the receiver stalls, the result
// register holds its value, the input register holds its transaction and
// the input stall is raised once both are full. The user must write the
// configuration registers through the plain write port only while no
// transaction is in flight; the block itself does not enforce this.
// Synchronous active-low reset loads the default segment lengths and jump
// width, returns the phase to SYNC, clears the sync counter, sets the segment
// counters to one, clears the pending edge and hard sync flags and empties both registers.
module can_bit_timing_sync_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cbts_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [cbts_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_edge_event,
    input  logic                      i_hs_write,
    input  logic                      i_hs_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_sample_strobe,
    output logic                      o_write_strobe,
    output logic [1:0]                o_phase_now
);

    logic [cbts_pkg::PHASE1_W-1:0] r_p1;
    logic [cbts_pkg::PHASE2_W-1:0] r_p2;
    logic [cbts_pkg::JUMP_W-1:0]   r_jw;

    logic r_s1_valid;
    logic r_in_edge;
    logic r_in_hs_wr;
    logic r_in_hs_val;

    cbts_pkg::t_phase r_phase, n_phase;
    logic [1:0]                     r_sync, n_sync;
    logic [cbts_pkg::PHASE1_W-1:0]  r_seg1, n_seg1;
    logic [cbts_pkg::PHASE2_W-1:0]  r_seg2, n_seg2;
    logic [cbts_pkg::JUMP_W-1:0]    r_len, n_len;
    logic [cbts_pkg::PHASE2_W-1:0]  r_shr, n_shr;
    logic r_win, n_win;
    logic r_edge_pend, n_edge_pend;
    logic r_hs_pend, n_hs_pend;
    logic r_hs_hap, n_hs_hap;
    logic r_sample, n_sample;
    logic r_write, n_write;

    logic       r_out_valid;
    logic       r_out_sample;
    logic       r_out_write;
    logic [1:0] r_out_phase;

    logic w_adv;
    logic w_load;

    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        logic [cbts_pkg::PHASE2_W-1:0] rem;
        logic [cbts_pkg::PHASE2_W-1:0] limit;
        logic [cbts_pkg::PHASE1_W:0]   seg1_end;

        n_phase     = r_phase;
        n_sync      = r_sync;
        n_seg1      = r_seg1;
        n_seg2      = r_seg2;
        n_len       = r_len;
        n_shr       = r_shr;
        n_win       = r_win;
        n_edge_pend = r_edge_pend;
        n_hs_pend   = r_hs_pend;
        n_hs_hap    = r_hs_hap;
        n_sample    = r_sample;
        n_write     = r_write;
        rem         = '0;
        limit       = '0;
        seg1_end    = '0;

        if (r_in_edge) begin
            n_edge_pend = 1'b1;
        end
        if (r_in_hs_wr) begin
            n_hs_pend = r_in_hs_val;
        end

        if (n_edge_pend && r_phase != cbts_pkg::PH_SYNC) begin
            n_edge_pend = 1'b0;
            if (r_phase == cbts_pkg::PH_SEG1) begin
                n_len = (r_seg1 > {2'b00, r_jw}) ? r_jw : r_seg1[cbts_pkg::JUMP_W-1:0];
            end else if (r_phase == cbts_pkg::PH_SEG2) begin
                rem   = (r_seg2 < r_p2) ? r_p2 - r_seg2 : '0;
                n_shr = (rem > {1'b0, r_jw}) ? {1'b0, r_jw} : rem;
                n_win = 1'b1;
            end
        end

        case (r_phase)
            cbts_pkg::PH_SEG1: begin
                if (n_hs_pend) begin
                    n_phase   = cbts_pkg::PH_SEG1;
                    n_sync    = '0;
                    n_seg1    = 5'd1;
                    n_seg2    = 4'd1;
                    n_len     = '0;
                    n_shr     = '0;
                    n_win     = 1'b0;
                    n_sample  = 1'b0;
                    n_write   = 1'b1;
                    n_hs_pend = 1'b0;
                    n_hs_hap  = 1'b1;
                end
                seg1_end = {1'b0, r_p1} + {3'b000, n_len};
                if ({1'b0, n_seg1} < seg1_end) begin
                    if (n_hs_hap) begin
                        n_write  = 1'b1;
                        n_hs_hap = 1'b0;
                    end else begin
                        n_write = 1'b0;
                    end
                    n_sample = 1'b0;
                end else begin
                    n_phase  = cbts_pkg::PH_SEG2;
                    n_sample = 1'b1;
                    n_write  = 1'b0;
                end
                n_seg1 = n_seg1 + 5'd1;
            end
            cbts_pkg::PH_SEG2: begin
                if (n_hs_pend) begin
                    n_phase   = cbts_pkg::PH_SEG1;
                    n_sync    = '0;
                    n_seg1    = 5'd1;
                    n_seg2    = 4'd1;
                    n_len     = '0;
                    n_shr     = '0;
                    n_win     = 1'b0;
                    n_sample  = 1'b0;
                    n_write   = 1'b1;
                    n_hs_pend = 1'b0;
                    n_hs_hap  = 1'b1;
                end
                limit = n_win ? ((r_p2 > n_shr) ? r_p2 - n_shr : '0) : r_p2;
                if (n_seg2 < limit) begin
                    n_sample = 1'b0;
                    n_write  = 1'b0;
                end else begin
                    n_phase  = n_win ? cbts_pkg::PH_SEG1 : cbts_pkg::PH_SYNC;
                    n_write  = n_win;
                    n_sync   = '0;
                    n_seg1   = 5'd1;
                    n_seg2   = 4'd1;
                    n_len    = '0;
                    n_shr    = '0;
                    n_win    = 1'b0;
                    n_sample = 1'b0;
                end
                n_seg2 = n_seg2 + 4'd1;
            end
            default: begin
                n_phase = cbts_pkg::PH_SYNC;
                if (r_sync == 2'd1) begin
                    n_phase  = cbts_pkg::PH_SEG1;
                    n_write  = 1'b1;
                    n_sample = 1'b0;
                end
                n_sync = r_sync + 2'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= cbts_pkg::PHASE1_RST;
            r_p2 <= cbts_pkg::PHASE2_RST;
            r_jw <= cbts_pkg::JUMP_RST;
        end else if (i_cfg_we) begin
            case (cbts_pkg::t_reg_idx'(i_cfg_idx))
                cbts_pkg::REG_PHASE1: r_p1 <= i_cfg_data[cbts_pkg::PHASE1_W-1:0];
                cbts_pkg::REG_PHASE2: r_p2 <= i_cfg_data[cbts_pkg::PHASE2_W-1:0];
                cbts_pkg::REG_JUMP:   r_jw <= i_cfg_data[cbts_pkg::JUMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cbts_pkg::PH_SYNC;
            r_sync      <= '0;
            r_seg1      <= 5'd1;
            r_seg2      <= 4'd1;
            r_len       <= '0;
            r_shr       <= '0;
            r_win       <= 1'b0;
            r_edge_pend <= 1'b0;
            r_hs_pend   <= 1'b0;
            r_hs_hap    <= 1'b0;
            r_sample    <= 1'b0;
            r_write     <= 1'b0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_sync      <= n_sync;
            r_seg1      <= n_seg1;
            r_seg2      <= n_seg2;
            r_len       <= n_len;
            r_shr       <= n_shr;
            r_win       <= n_win;
            r_edge_pend <= n_edge_pend;
            r_hs_pend   <= n_hs_pend;
            r_hs_hap    <= n_hs_hap;
            r_sample    <= n_sample;
            r_write     <= n_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_edge   <= i_edge_event;
            r_in_hs_wr  <= i_hs_write;
            r_in_hs_val <= i_hs_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_sample <= n_sample;
            r_out_write  <= n_write;
            r_out_phase  <= n_phase;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_strobe = r_out_sample;
    assign o_write_strobe  = r_out_write;
    assign o_phase_now     = r_out_phase;

endmodule

[tb/can_bit_timing_sync_top_test.sv]
`timescale 1ns / 100ps

module can_bit_timing_sync_top_test;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned WAIT_MAX       = 11;
    localparam int unsigned RANDOM_ITEMS   = 205;

    typedef struct packed {
        logic       sample_strobe;
        logic       write_strobe;
        logic [1:0] phase_now;
    } t_quantum_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [cbts_pkg::IDX_W-1:0]   i_cfg_idx;
    logic [cbts_pkg::CFG_W-1:0]   i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_edge_event;
    logic                         i_hs_write;
    logic                         i_hs_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_sample_strobe;
    logic                         o_write_strobe;
    logic [1:0]                   o_phase_now;

    t_quantum_result    quantum_results_q[$];
    int unsigned        fail_count = 0;
    bit                 send_quiet = 1'b0;
    bit                 recv_quiet = 1'b0;
    int unsigned        recv_hold_off = 0;
    int unsigned        stall_left = 0;

    logic [cbts_pkg::PHASE1_W-1:0] seg1_len;
    logic [cbts_pkg::PHASE2_W-1:0] seg2_len;
    logic [cbts_pkg::JUMP_W-1:0]   jump_len;
    cbts_pkg::t_phase              bt_phase;
    logic [1:0]                    bt_sync_cnt;
    logic [cbts_pkg::PHASE1_W-1:0] bt_seg1_cnt;
    logic [cbts_pkg::PHASE2_W-1:0] bt_seg2_cnt;
    logic [cbts_pkg::JUMP_W-1:0]   bt_lengthen;
    logic [cbts_pkg::PHASE2_W-1:0] bt_shorten;
    bit                            bt_shorten_win;
    bit                            bt_edge_pend;
    bit                            bt_hs_pend;
    bit                            bt_hs_taken;
    bit                            bt_sample;
    bit                            bt_write;

    can_bit_timing_sync_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_edge_event    (i_edge_event),
        .i_hs_write      (i_hs_write),
        .i_hs_value      (i_hs_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_strobe (o_sample_strobe),
        .o_write_strobe  (o_write_strobe),
        .o_phase_now     (o_phase_now)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    function void clear_bit_counters();
        bt_sync_cnt    = '0;
        bt_seg1_cnt    = 5'd1;
        bt_seg2_cnt    = 4'd1;
        bt_lengthen    = '0;
        bt_shorten     = '0;
        bt_shorten_win = 1'b0;
        bt_sample      = 1'b0;
        bt_write       = 1'b0;
    endfunction

    function void reset_bit_timing();
        seg1_len     = cbts_pkg::PHASE1_RST;
        seg2_len     = cbts_pkg::PHASE2_RST;
        jump_len     = cbts_pkg::JUMP_RST;
        bt_phase     = cbts_pkg::PH_SYNC;
        clear_bit_counters();
        bt_edge_pend = 1'b0;
        bt_hs_pend   = 1'b0;
        bt_hs_taken  = 1'b0;
    endfunction

    function void take_hard_sync();
        if (bt_hs_pend) begin
            bt_phase = cbts_pkg::PH_SEG1;
            clear_bit_counters();
            bt_write    = 1'b1;
            bt_hs_pend  = 1'b0;
            bt_hs_taken = 1'b1;
        end
    endfunction

    function void take_resync_edge();
        int unsigned room;
        if (!bt_edge_pend || bt_phase == cbts_pkg::PH_SYNC) begin
            return;
        end
        bt_edge_pend = 1'b0;
        if (bt_phase == cbts_pkg::PH_SEG1) begin
            room = bt_seg1_cnt;
            if (room > jump_len) begin
                room = jump_len;
            end
            bt_lengthen = room[cbts_pkg::JUMP_W-1:0];
        end else if (bt_phase == cbts_pkg::PH_SEG2) begin
            room = (bt_seg2_cnt < seg2_len) ? seg2_len - bt_seg2_cnt : 0;
            if (room > jump_len) begin
                room = jump_len;
            end
            bt_shorten     = room[cbts_pkg::PHASE2_W-1:0];
            bt_shorten_win = 1'b1;
        end
    endfunction

    function void predict_quantum(input bit edge_event, input bit hs_write, input bit hs_value);
        int unsigned     seg2_limit;
        t_quantum_result res;
        if (edge_event) begin
            bt_edge_pend = 1'b1;
        end
        if (hs_write) begin
            bt_hs_pend = hs_value;
        end
        take_resync_edge();
        case (bt_phase)
            cbts_pkg::PH_SEG1: begin
                take_hard_sync();
                if (int'(bt_seg1_cnt) < int'(seg1_len) + int'(bt_lengthen)) begin
                    if (bt_hs_taken) begin
                        bt_write    = 1'b1;
                        bt_hs_taken = 1'b0;
                    end else begin
                        bt_write = 1'b0;
                    end
                    bt_sample = 1'b0;
                end else begin
                    bt_phase  = cbts_pkg::PH_SEG2;
                    bt_sample = 1'b1;
                    bt_write  = 1'b0;
                end
                bt_seg1_cnt = bt_seg1_cnt + 1'b1;
            end
            cbts_pkg::PH_SEG2: begin
                // A hard sync taken here still falls through to the segment 2 logic.
                take_hard_sync();
                if (!bt_shorten_win) begin
                    if (bt_seg2_cnt < seg2_len) begin
                        bt_sample = 1'b0;
                        bt_write  = 1'b0;
                    end else begin
                        bt_phase = cbts_pkg::PH_SYNC;
                        clear_bit_counters();
                    end
                end else begin
                    seg2_limit = (seg2_len > bt_shorten) ? seg2_len - bt_shorten : 0;
                    if (bt_seg2_cnt < seg2_limit) begin
                        bt_sample = 1'b0;
                        bt_write  = 1'b0;
                    end else begin
                        bt_phase = cbts_pkg::PH_SEG1;
                        clear_bit_counters();
                        bt_write = 1'b1;
                    end
                end
                bt_seg2_cnt = bt_seg2_cnt + 1'b1;
            end
            default: begin
                bt_phase = cbts_pkg::PH_SYNC;
                if (bt_sync_cnt == 2'd1) begin
                    bt_phase  = cbts_pkg::PH_SEG1;
                    bt_write  = 1'b1;
                    bt_sample = 1'b0;
                end
                bt_sync_cnt = bt_sync_cnt + 1'b1;
            end
        endcase
        res.sample_strobe = bt_sample;
        res.write_strobe  = bt_write;
        res.phase_now     = bt_phase;
        quantum_results_q.push_back(res);
    endfunction

    task automatic send_quantum(input bit edge_event, input bit hs_write, input bit hs_value);
        int unsigned gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_edge_event <= edge_event;
        i_hs_write   <= hs_write;
        i_hs_value   <= hs_value;
        do @(posedge i_clk); while (o_in_stall);
        predict_quantum(edge_event, hs_write, hs_value);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (quantum_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_one_reg(input cbts_pkg::t_reg_idx idx,
                                 input logic [cbts_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            cbts_pkg::REG_PHASE1: seg1_len = data[cbts_pkg::PHASE1_W-1:0];
            cbts_pkg::REG_PHASE2: seg2_len = data[cbts_pkg::PHASE2_W-1:0];
            cbts_pkg::REG_JUMP:   jump_len = data[cbts_pkg::JUMP_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic write_timing_regs(input int unsigned p1, input int unsigned p2,
                                     input int unsigned jw);
        wait_idle();
        write_one_reg(cbts_pkg::REG_PHASE1, p1[cbts_pkg::CFG_W-1:0]);
        write_one_reg(cbts_pkg::REG_PHASE2, p2[cbts_pkg::CFG_W-1:0]);
        write_one_reg(cbts_pkg::REG_JUMP, jw[cbts_pkg::CFG_W-1:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic advance_to_phase(input cbts_pkg::t_phase target);
        int unsigned n;
        n = 0;
        while (bt_phase != target && n < 40) begin
            send_quantum(1'b0, 1'b0, 1'b0);
            n++;
        end
    endtask

    task automatic test_reset_timing();
        send_quantum(1'b1, 1'b0, 1'b0);
        send_quantum(1'b0, 1'b1, 1'b1);
        send_quantum(1'b0, 1'b1, 1'b0);
        repeat (3) send_quantum(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_hard_sync();
        write_timing_regs(1, 2, 4);
        advance_to_phase(cbts_pkg::PH_SEG2);
        send_quantum(1'b0, 1'b1, 1'b1);
        send_quantum(1'b0, 1'b0, 1'b0);
        advance_to_phase(cbts_pkg::PH_SEG1);
        send_quantum(1'b0, 1'b1, 1'b1);
        send_quantum(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_resync_edges();
        advance_to_phase(cbts_pkg::PH_SEG2);
        send_quantum(1'b1, 1'b0, 1'b0);
        advance_to_phase(cbts_pkg::PH_SEG1);
        send_quantum(1'b1, 1'b0, 1'b0);
        write_timing_regs(16, 8, 0);
        advance_to_phase(cbts_pkg::PH_SEG1);
        send_quantum(1'b1, 1'b0, 1'b0);
        send_quantum(1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned p1;
        int unsigned p2;
        int unsigned jw;
        bit          noisy;
        bit          ev;
        bit          hw;
        bit          hv;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin p1 = 1;  p2 = 2; jw = 0; end
                1: begin p1 = 16; p2 = 8; jw = 4; end
                2: begin p1 = 16; p2 = 2; jw = 4; end
                3: begin p1 = 1;  p2 = 8; jw = 0; end
                default: begin
                    p1 = $urandom_range(1, 16);
                    p2 = $urandom_range(2, 8);
                    jw = $urandom_range(0, 4);
                end
            endcase
            write_timing_regs(p1, p2, jw);
            noisy = 1'b0;
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    send_quiet = ($urandom_range(0, 3) == 0);
                    recv_quiet = ($urandom_range(0, 3) == 0);
                    noisy      = ($urandom_range(0, 7) == 0);
                end
                if (noisy) begin
                    ev = 1'($urandom_range(0, 1));
                    hw = 1'($urandom_range(0, 1));
                    hv = 1'($urandom_range(0, 1));
                end else begin
                    ev = ($urandom_range(0, 5) == 0);
                    hw = ($urandom_range(0, 11) == 0);
                    hv = ($urandom_range(0, 3) != 0);
                end
                send_quantum(ev, hw, hv);
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        write_timing_regs($urandom_range(1, 16), $urandom_range(2, 8), $urandom_range(0, 4));
        send_quiet    = 1'b1;
        recv_hold_off = 80;
        for (int n = 0; n < 40; n++) begin
            send_quantum($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                         1'($urandom_range(0, 1)));
        end
        send_quiet = 1'b0;
    endtask

    initial begin
        t_quantum_result want;
        i_out_stall = 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (quantum_results_q.size() == 0) begin
                    $error("result transaction arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = quantum_results_q.pop_front();
                    if (o_sample_strobe !== want.sample_strobe) begin
                        $error("sample_strobe: expected %0d, actual %0d",
                               want.sample_strobe, o_sample_strobe);
                        fail_count++;
                    end
                    if (o_write_strobe !== want.write_strobe) begin
                        $error("write_strobe: expected %0d, actual %0d",
                               want.write_strobe, o_write_strobe);
                        fail_count++;
                    end
                    if (o_phase_now !== want.phase_now) begin
                        $error("phase_now: expected %0d, actual %0d",
                               want.phase_now, o_phase_now);
                        fail_count++;
                    end
                end
                stall_left = draw_wait(recv_quiet);
            end
            @(negedge i_clk);
            if (recv_hold_off > 0) begin
                recv_hold_off--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("can_bit_timing_sync_top_test failed");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = cbts_pkg::REG_PHASE1;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_edge_event = 1'b0;
        i_hs_write   = 1'b0;
        i_hs_value   = 1'b0;
        reset_bit_timing();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timing();
        test_hard_sync();
        test_resync_edges();
        test_random_traffic();
        test_backpressure();
        wait_idle();

        if (fail_count == 0 && quantum_results_q.size() == 0) begin
            $display("can_bit_timing_sync_top_test passed");
        end else begin
            $display("can_bit_timing_sync_top_test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/cbts_pkg.sv
sv/can_bit_timing_sync_top.sv
tb/can_bit_timing_sync_top_test.sv
